### src/tksl_pkg.sv
// Shared types and constants of the top-k signal strength list.
// Holds the request, response and slot word layouts and the opcode codes.
// Depends on nothing; every other file imports it.
package tksl_pkg;

    localparam int LIST_DEPTH_DEFAULT = 32;

    localparam logic [1:0] OP_INSERT = 2'd0;
    localparam logic [1:0] OP_CLEAR  = 2'd1;
    localparam logic [1:0] OP_READ   = 2'd2;
    localparam logic [1:0] OP_NOP    = 2'd3;

    typedef struct packed {
        logic [1:0]        opcode;
        logic signed [7:0] new_rssi;
        logic [7:0]        new_channel;
        logic              new_secure;
        logic [47:0]       new_bssid;
        logic [31:0]       new_name_tag;
        logic [4:0]        read_index;
    } req_word_t;

    typedef struct packed {
        logic [5:0]        entry_count;
        logic              was_dropped;
        logic [4:0]        placed_position;
        logic              read_valid;
        logic signed [7:0] read_rssi;
        logic [7:0]        read_channel;
        logic              read_secure;
        logic [47:0]       read_bssid;
        logic [31:0]       read_name_tag;
    } rsp_word_t;

    typedef struct packed {
        logic signed [7:0] rssi;
        logic [7:0]        channel;
        logic              secure;
        logic [47:0]       bssid;
        logic [31:0]       name_tag;
    } slot_t;

    typedef struct packed {
        logic res_valid;
        logic busy;
    } seq_status_t;

endpackage

### src/tksl_slot_ram.sv
// Slot memory of the list: one write port and one registered read port.
// Read data appears in the cycle after the address. Depends on tksl_pkg.
module tksl_slot_ram #(
    parameter int LIST_DEPTH = tksl_pkg::LIST_DEPTH_DEFAULT,
    parameter int AW         = $clog2(LIST_DEPTH)
) (
    input  logic            clk,
    input  logic            wr_en,
    input  logic [AW-1:0]   wr_addr,
    input  tksl_pkg::slot_t wr_data,
    input  logic [AW-1:0]   rd_addr,
    output tksl_pkg::slot_t rd_data
);
    import tksl_pkg::*;

    slot_t mem [LIST_DEPTH];
    slot_t rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

### src/tksl_seq.sv
// Sequencer of the list: decodes each request word and walks the slot memory.
// An insert shifts weaker entries down one slot a cycle until the record fits.
// Depends on tksl_pkg and drives the ports of tksl_slot_ram.
module tksl_seq #(
    parameter int LIST_DEPTH = tksl_pkg::LIST_DEPTH_DEFAULT,
    parameter int AW         = $clog2(LIST_DEPTH),
    parameter int CW         = $clog2(LIST_DEPTH + 1)
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  req_take,
    input  tksl_pkg::req_word_t   req_word,
    input  logic                  out_free,
    output tksl_pkg::seq_status_t status,
    output tksl_pkg::rsp_word_t   res_word,
    output logic [CW-1:0]         count,
    output logic                  wr_en,
    output logic [AW-1:0]         wr_addr,
    output tksl_pkg::slot_t       wr_data,
    output logic [AW-1:0]         rd_addr,
    input  tksl_pkg::slot_t       rd_data
);
    import tksl_pkg::*;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_CHECK = 3'd1;
    localparam logic [2:0] S_WALK  = 3'd2;
    localparam logic [2:0] S_READ  = 3'd3;
    localparam logic [2:0] S_DONE  = 3'd4;

    logic [2:0]    state_reg, state_next;
    logic [CW-1:0] count_reg, count_next;
    logic [AW-1:0] pos_reg, pos_next;
    slot_t         rec_reg, rec_next;
    logic          hit_reg, hit_next;
    rsp_word_t     res_reg, res_next;

    logic [AW+5:0] idx_wide;
    logic [CW+5:0] count_wide;
    logic [AW+4:0] pos_wide;
    logic          full;

    assign idx_wide   = (AW + 6)'(req_word.read_index);
    assign count_wide = (CW + 6)'(count_reg);
    assign pos_wide   = (AW + 5)'(pos_reg);
    assign full       = (count_reg >= CW'(LIST_DEPTH));

    always_comb
    begin
        state_next = state_reg;
        count_next = count_reg;
        pos_next   = pos_reg;
        rec_next   = rec_reg;
        hit_next   = hit_reg;
        res_next   = res_reg;
        wr_en      = 1'b0;
        wr_addr    = pos_reg;
        wr_data    = rec_reg;
        rd_addr    = pos_reg - AW'(1);
        case (state_reg)
            S_IDLE:
            begin
                if (req_take)
                begin
                    res_next = '0;
                    rec_next.rssi     = req_word.new_rssi;
                    rec_next.channel  = req_word.new_channel;
                    rec_next.secure   = req_word.new_secure;
                    rec_next.bssid    = req_word.new_bssid;
                    rec_next.name_tag = req_word.new_name_tag;
                    case (req_word.opcode)
                        OP_INSERT:
                        begin
                            if (full)
                            begin
                                rd_addr    = AW'(LIST_DEPTH - 1);
                                state_next = S_CHECK;
                            end
                            else
                            begin
                                pos_next   = count_reg[AW-1:0];
                                rd_addr    = count_reg[AW-1:0] - AW'(1);
                                count_next = count_reg + CW'(1);
                                state_next = S_WALK;
                            end
                        end
                        OP_CLEAR:
                        begin
                            count_next = '0;
                            state_next = S_DONE;
                        end
                        OP_READ:
                        begin
                            rd_addr    = idx_wide[AW-1:0];
                            hit_next   = (idx_wide < (AW + 6)'(count_reg));
                            state_next = S_READ;
                        end
                        default:
                        begin
                            state_next = S_DONE;
                        end
                    endcase
                end
            end
            S_CHECK:
            begin
                if (rec_reg.rssi <= rd_data.rssi)
                begin
                    res_next.was_dropped = 1'b1;
                    state_next = S_DONE;
                end
                else
                begin
                    pos_next   = AW'(LIST_DEPTH - 1);
                    rd_addr    = AW'(LIST_DEPTH - 2);
                    state_next = S_WALK;
                end
            end
            S_WALK:
            begin
                wr_en = 1'b1;
                if ((pos_reg != '0) && (rd_data.rssi < rec_reg.rssi))
                begin
                    wr_data  = rd_data;
                    rd_addr  = pos_reg - AW'(2);
                    pos_next = pos_reg - AW'(1);
                end
                else
                begin
                    res_next.placed_position = pos_wide[4:0];
                    state_next = S_DONE;
                end
            end
            S_READ:
            begin
                if (hit_reg)
                begin
                    res_next.read_valid    = 1'b1;
                    res_next.read_rssi     = rd_data.rssi;
                    res_next.read_channel  = rd_data.channel;
                    res_next.read_secure   = rd_data.secure;
                    res_next.read_bssid    = rd_data.bssid;
                    res_next.read_name_tag = rd_data.name_tag;
                end
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pos_reg <= pos_next;
        rec_reg <= rec_next;
        hit_reg <= hit_next;
        res_reg <= res_next;
    end

    always_comb
    begin
        res_word             = res_reg;
        res_word.entry_count = count_wide[5:0];
    end

    assign status.res_valid = (state_reg == S_DONE);
    assign status.busy      = (state_reg != S_IDLE);
    assign count            = count_reg;

endmodule

### src/top_k_signal_strength_list_core.sv
// Top level of the top-k signal strength list: handshakes and result register.
// Instantiates tksl_seq and tksl_slot_ram; depends on tksl_pkg.
//
//   channel | direction | handshake              | word
//   req     | in        | req_valid / req_stall  | tksl_pkg::req_word_t
//   rsp     | out       | rsp_valid / rsp_stall  | tksl_pkg::rsp_word_t
//
// One request word is worked at a time. A clear or no-op goes straight to the
// done state, and a read passes through the read state first, as the slot
// memory has a registered read port. An insert walks the memory, shifting one
// weaker entry down at each step, and checks the last slot first when the list
// is full; an insert dropped as too weak ends after that check.
// Reset clears the entry count; the slots need no clearing pass.
// A stalled response waits in its register while the next request is taken.
module top_k_signal_strength_list_core #(
    parameter int LIST_DEPTH = tksl_pkg::LIST_DEPTH_DEFAULT
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                req_valid,
    output logic                req_stall,
    input  tksl_pkg::req_word_t req_word,
    output logic                rsp_valid,
    input  logic                rsp_stall,
    output tksl_pkg::rsp_word_t rsp_word
);
    import tksl_pkg::*;

    localparam int AW = $clog2(LIST_DEPTH);
    localparam int CW = $clog2(LIST_DEPTH + 1);

    seq_status_t   status;
    rsp_word_t     res_word;
    logic [CW-1:0] count;
    logic          req_take;
    logic          out_free;
    logic          wr_en;
    logic [AW-1:0] wr_addr;
    logic [AW-1:0] rd_addr;
    slot_t         wr_data;
    slot_t         rd_data;

    logic          rsp_valid_reg;
    rsp_word_t     rsp_word_reg;

    assign req_stall = status.busy;
    assign req_take  = req_valid && !status.busy;
    assign out_free  = !rsp_valid_reg || !rsp_stall;

    tksl_seq #(
        .LIST_DEPTH(LIST_DEPTH),
        .AW        (AW),
        .CW        (CW)
    ) u_seq (
        .clk     (clk),
        .rst_n   (rst_n),
        .req_take(req_take),
        .req_word(req_word),
        .out_free(out_free),
        .status  (status),
        .res_word(res_word),
        .count   (count),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    tksl_slot_ram #(
        .LIST_DEPTH(LIST_DEPTH),
        .AW        (AW)
    ) u_ram (
        .clk    (clk),
        .wr_en  (wr_en),
        .wr_addr(wr_addr),
        .wr_data(wr_data),
        .rd_addr(rd_addr),
        .rd_data(rd_data)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            rsp_valid_reg <= status.res_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_free && status.res_valid)
        begin
            rsp_word_reg <= res_word;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp_word  = rsp_word_reg;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count <= CW'(LIST_DEPTH))
        else $error("entry count above list depth");

    a_take_busy: assert property (@(posedge clk) disable iff (!rst_n)
        req_take |=> status.busy)
        else $error("sequencer idle after taking a request");

    a_drop_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && rsp_word.was_dropped) |->
            (rsp_word.placed_position == 5'd0 && !rsp_word.read_valid))
        else $error("dropped insert reports a placement or read");

    a_write_busy: assert property (@(posedge clk) disable iff (!rst_n)
        wr_en |-> (status.busy && !status.res_valid))
        else $error("slot write outside an insert walk");

endmodule

### tb/top_k_signal_strength_list_core_tb.sv
`timescale 1ns / 100ps
// Self-checking testbench for the top-k signal strength list core.
// Drives request words, predicts every response word, checks field by field.
// Depends on tksl_pkg and top_k_signal_strength_list_core.
module top_k_signal_strength_list_core_tb;

    import tksl_pkg::*;

    localparam int DEPTH       = 32;
    localparam int ITEMS       = 1300;
    localparam int CYCLE_LIMIT = 500000;
    localparam int SQUEEZE_LEN = 400;

    typedef struct packed {
        req_word_t cmd;
        logic      known;
        rsp_word_t want;
    } drill_row_t;

    logic      clk = 1'b0;
    logic      rst_n = 1'b0;
    logic      req_valid = 1'b0;
    logic      req_stall;
    req_word_t req_word = '0;
    logic      rsp_valid;
    logic      rsp_stall = 1'b0;
    rsp_word_t rsp_word;

    slot_t       rank_table [DEPTH];
    int unsigned rank_count = 0;
    rsp_word_t   pending_rsp [$];
    drill_row_t  drill [$];
    int          words_sent = 0;
    int          mismatch_count = 0;
    int          cycle_count = 0;
    bit          calm = 1'b0;
    bit          squeeze_now = 1'b0;
    bit          squeeze_done = 1'b0;

    top_k_signal_strength_list_core #(.LIST_DEPTH(DEPTH)) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req_word  (req_word),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp_word  (rsp_word)
    );

    always #10 clk = ~clk;

    function automatic rsp_word_t apply_scan_op(input req_word_t w);
        rsp_word_t   r;
        slot_t       tmp;
        int unsigned pos;
        bit          take;
        r = '0;
        case (w.opcode)
            OP_INSERT:
            begin
                take = 1'b1;
                if (rank_count < DEPTH)
                begin
                    pos = rank_count;
                    rank_count++;
                end
                else
                begin
                    pos = DEPTH - 1;
                    if ($signed(w.new_rssi) <= $signed(rank_table[pos].rssi))
                        take = 1'b0;
                end
                if (take)
                begin
                    rank_table[pos] = '{rssi: w.new_rssi, channel: w.new_channel,
                                        secure: w.new_secure, bssid: w.new_bssid,
                                        name_tag: w.new_name_tag};
                    while (pos > 0 &&
                           $signed(rank_table[pos].rssi) > $signed(rank_table[pos - 1].rssi))
                    begin
                        tmp = rank_table[pos];
                        rank_table[pos] = rank_table[pos - 1];
                        rank_table[pos - 1] = tmp;
                        pos--;
                    end
                    r.placed_position = pos[4:0];
                end
                else
                    r.was_dropped = 1'b1;
            end
            OP_CLEAR:
                rank_count = 0;
            OP_READ:
            begin
                if (w.read_index < rank_count)
                begin
                    r.read_valid    = 1'b1;
                    r.read_rssi     = rank_table[w.read_index].rssi;
                    r.read_channel  = rank_table[w.read_index].channel;
                    r.read_secure   = rank_table[w.read_index].secure;
                    r.read_bssid    = rank_table[w.read_index].bssid;
                    r.read_name_tag = rank_table[w.read_index].name_tag;
                end
            end
            default:
                r = '0;
        endcase
        r.entry_count = rank_count[5:0];
        return r;
    endfunction

    function automatic req_word_t mk_req(input logic [1:0] op, input logic [7:0] rssi,
                                         input logic [7:0] chan, input logic sec,
                                         input logic [47:0] bssid, input logic [31:0] tag,
                                         input logic [4:0] idx);
        return '{opcode: op, new_rssi: rssi, new_channel: chan, new_secure: sec,
                 new_bssid: bssid, new_name_tag: tag, read_index: idx};
    endfunction

    function automatic rsp_word_t mk_rsp(input logic [5:0] count, input logic drop,
                                         input logic [4:0] place, input logic valid,
                                         input logic [7:0] rssi, input logic [7:0] chan,
                                         input logic sec, input logic [47:0] bssid,
                                         input logic [31:0] tag);
        return '{entry_count: count, was_dropped: drop, placed_position: place,
                 read_valid: valid, read_rssi: rssi, read_channel: chan, read_secure: sec,
                 read_bssid: bssid, read_name_tag: tag};
    endfunction

    function automatic req_word_t random_record(input bit narrow);
        req_word_t w;
        w.opcode       = OP_INSERT;
        w.new_rssi     = narrow ? 8'($urandom_range(0, 6) - 60) : 8'($urandom_range(0, 255));
        w.new_channel  = 8'($urandom_range(0, 255));
        w.new_secure   = 1'($urandom_range(0, 1));
        w.new_bssid    = {16'($urandom()), 32'($urandom())};
        w.new_name_tag = 32'($urandom());
        w.read_index   = 5'($urandom_range(0, 31));
        return w;
    endfunction

    function automatic int idle_gap();
        int n;
        n = 0;
        if (!calm && $urandom_range(0, 99) < 21)
            n = $urandom_range(1, 40);
        return n;
    endfunction

    task automatic add_row(input req_word_t c, input logic k, input rsp_word_t r);
        drill.push_back('{cmd: c, known: k, want: r});
    endtask

    task automatic send_word(input req_word_t w, input logic known, input rsp_word_t want);
        int        gap;
        rsp_word_t got;
        gap = idle_gap();
        if (gap > 0)
        begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_valid <= 1'b1;
        req_word <= w;
        do @(posedge clk); while (req_stall);
        got = apply_scan_op(w);
        pending_rsp.push_back(known ? want : got);
        words_sent++;
    endtask

    task automatic check_field(input string name, input logic [63:0] want,
                               input logic [63:0] got);
        if (want !== got)
        begin
            $error("%s: expected %0h, got %0h", name, want, got);
            mismatch_count++;
        end
    endtask

    always @(posedge clk)
    begin : rsp_check
        rsp_word_t want;
        if (rst_n && rsp_valid && !rsp_stall)
        begin
            if (pending_rsp.size() == 0)
            begin
                $error("response word with nothing pending: %0h", rsp_word);
                mismatch_count++;
            end
            else
            begin
                want = pending_rsp.pop_front();
                check_field("entry_count", want.entry_count, rsp_word.entry_count);
                check_field("was_dropped", want.was_dropped, rsp_word.was_dropped);
                check_field("placed_position", want.placed_position, rsp_word.placed_position);
                check_field("read_valid", want.read_valid, rsp_word.read_valid);
                check_field("read_rssi", want.read_rssi, rsp_word.read_rssi);
                check_field("read_channel", want.read_channel, rsp_word.read_channel);
                check_field("read_secure", want.read_secure, rsp_word.read_secure);
                check_field("read_bssid", want.read_bssid, rsp_word.read_bssid);
                check_field("read_name_tag", want.read_name_tag, rsp_word.read_name_tag);
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Some tests failed");
            $finish;
        end
    end

    initial
    begin : rsp_side
        int held_cycles;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (squeeze_now && !squeeze_done)
            begin
                rsp_stall <= 1'b1;
                for (held_cycles = 0; held_cycles < SQUEEZE_LEN; held_cycles++)
                    @(posedge clk);
                squeeze_done = 1'b1;
            end
            rsp_stall <= !calm && ($urandom_range(0, 99) < 21);
        end
    end

    initial
    begin : stimulus
        int        k;
        int        fill;
        bit        narrow;
        req_word_t w;
        add_row(mk_req(OP_READ, 0, 0, 0, 0, 0, 0), 1, mk_rsp(0, 0, 0, 0, 0, 0, 0, 0, 0));
        add_row(mk_req(OP_NOP, 8'h7f, 8'hff, 1, '1, '1, 5'd31), 1,
                mk_rsp(0, 0, 0, 0, 0, 0, 0, 0, 0));
        add_row(mk_req(OP_CLEAR, 0, 0, 0, 0, 0, 0), 1, mk_rsp(0, 0, 0, 0, 0, 0, 0, 0, 0));
        add_row(mk_req(OP_INSERT, 8'h7f, 8'hff, 1, '1, '1, 0), 1,
                mk_rsp(1, 0, 0, 0, 0, 0, 0, 0, 0));
        add_row(mk_req(OP_INSERT, 8'h80, 0, 0, 0, 0, 5'd31), 1,
                mk_rsp(2, 0, 1, 0, 0, 0, 0, 0, 0));
        add_row(mk_req(OP_READ, 0, 0, 0, 0, 0, 0), 1,
                mk_rsp(2, 0, 0, 1, 8'h7f, 8'hff, 1, '1, '1));
        add_row(mk_req(OP_READ, 0, 0, 0, 0, 0, 1), 1,
                mk_rsp(2, 0, 0, 1, 8'h80, 0, 0, 0, 0));
        add_row(mk_req(OP_READ, 0, 0, 0, 0, 0, 2), 1, mk_rsp(2, 0, 0, 0, 0, 0, 0, 0, 0));
        add_row(mk_req(OP_READ, 8'hff, 8'hff, 1, '1, '1, 5'd31), 1,
                mk_rsp(2, 0, 0, 0, 0, 0, 0, 0, 0));
        add_row(mk_req(OP_INSERT, 8'h7f, 8'h01, 0, 48'h1, 32'h1, 0), 0, '0);
        add_row(mk_req(OP_INSERT, 8'h05, 8'h24, 1, 48'h0a0b0c0d0e0f, 32'h5a5a, 0), 0, '0);
        add_row(mk_req(OP_INSERT, 8'h80, 8'h0b, 0, 48'h2, 32'h2, 0), 0, '0);
        add_row(mk_req(OP_READ, 0, 0, 0, 0, 0, 1), 0, '0);
        add_row(mk_req(OP_READ, 0, 0, 0, 0, 0, 4), 0, '0);
        add_row(mk_req(OP_READ, 0, 0, 0, 0, 0, 5), 0, '0);
        add_row(mk_req(OP_NOP, 0, 0, 0, 0, 0, 0), 0, '0);
        add_row(mk_req(OP_CLEAR, 8'hff, 8'hff, 1, '1, '1, 5'd31), 1,
                mk_rsp(0, 0, 0, 0, 0, 0, 0, 0, 0));
        add_row(mk_req(OP_READ, 0, 0, 0, 0, 0, 0), 1, mk_rsp(0, 0, 0, 0, 0, 0, 0, 0, 0));
        add_row(mk_req(OP_INSERT, 8'hff, 8'h06, 1, 48'h123456789abc, 32'hdeadbeef, 0), 1,
                mk_rsp(1, 0, 0, 0, 0, 0, 0, 0, 0));

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (drill[i])
            send_word(drill[i].cmd, drill[i].known, drill[i].want);

        while (words_sent < ITEMS)
        begin
            if (words_sent > 300)
                squeeze_now = 1'b1;
            calm = (words_sent >= 600 && words_sent < 800);
            if ($urandom_range(0, 99) < 80)
            begin
                if ($urandom_range(0, 1) == 0)
                    send_word(mk_req(OP_CLEAR, 0, 0, 0, 0, 0, 0), 0, '0);
                fill = $urandom_range(1, 48);
                narrow = $urandom_range(0, 1);
                for (k = 0; k < fill; k++)
                begin
                    send_word(random_record(narrow), 0, '0);
                    if ($urandom_range(0, 3) == 0)
                    begin
                        w = random_record(0);
                        w.opcode = OP_READ;
                        send_word(w, 0, '0);
                    end
                end
            end
            else
            begin
                repeat ($urandom_range(1, 6))
                begin
                    w = random_record(0);
                    w.opcode = 2'($urandom_range(0, 3));
                    send_word(w, 0, '0);
                end
            end
        end
        req_valid <= 1'b0;

        while (pending_rsp.size() != 0)
            @(posedge clk);
        repeat (60) @(posedge clk);

        if (mismatch_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

### sim.f
src/tksl_pkg.sv
src/tksl_slot_ram.sv
src/tksl_seq.sv
src/top_k_signal_strength_list_core.sv
tb/top_k_signal_strength_list_core_tb.sv
